// ===== rtl/rrp_pkg.sv =====
// ============================================================================
// Row record parser package
// Parser phases, tag and result codes, and the state and result records
// shared by the step logic and the top level.
// ============================================================================
package rrp_pkg;

    typedef enum logic [2:0] {
        PH_CNT_LO,
        PH_CNT_HI,
        PH_TAG,
        PH_FIXED,
        PH_BOOL,
        PH_TLEN,
        PH_TEXT,
        PH_TRAIL
    } phase_t;

    localparam logic [7:0] TAG_INT     = 8'd1;
    localparam logic [7:0] TAG_TEXT    = 8'd2;
    localparam logic [7:0] TAG_BOOLEAN = 8'd3;
    localparam logic [7:0] TAG_FLOAT   = 8'd4;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_INT   = 3'd0;
    localparam kind_t KIND_FLOAT = 3'd1;
    localparam kind_t KIND_BOOL  = 3'd2;
    localparam kind_t KIND_THDR  = 3'd3;
    localparam kind_t KIND_TBYTE = 3'd4;
    localparam kind_t KIND_EMPTY = 3'd6;
    localparam kind_t KIND_ERROR = 3'd7;

    typedef logic [1:0] err_code_t;

    localparam err_code_t ERR_TRUNCATED    = 2'd0;
    localparam err_code_t ERR_UNKNOWN_TAG  = 2'd1;
    localparam err_code_t ERR_INVALID_BOOL = 2'd2;
    localparam err_code_t ERR_TRAILING     = 2'd3;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  byte_index;
        logic [63:0] accumulator;
        logic [15:0] columns_total;
        logic [15:0] column_index;
        logic [31:0] text_remaining;
        logic [1:0]  current_type;
        logic        discarding;
    } parse_state_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        phase:          PH_CNT_LO,
        byte_index:     4'd0,
        accumulator:    64'd0,
        columns_total:  16'd0,
        column_index:   16'd0,
        text_remaining: 32'd0,
        current_type:   2'd0,
        discarding:     1'b0
    };

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [63:0] value;
        logic [15:0] column;
        err_code_t   error_code;
        logic        last;
    } result_t;

endpackage

// ===== rtl/rrp_step.sv =====
// ============================================================================
// Row record parser step
// Consumes one byte against the current parser state and produces the next
// state and at most one result.
// ============================================================================
module rrp_step (
    input  rrp_pkg::parse_state_t state_i,
    input  logic [7:0]            data_byte_i,
    input  logic                  end_of_record_i,
    output rrp_pkg::parse_state_t state_next_o,
    output rrp_pkg::result_t      result_o
);

    rrp_pkg::parse_state_t prov;
    logic                  have;
    logic                  err;
    rrp_pkg::err_code_t    code;
    rrp_pkg::kind_t        kind;
    logic [63:0]           value;
    logic [15:0]           col;

    logic [63:0] acc_merged;
    logic [3:0]  bi_inc;
    logic [15:0] col_inc;
    logic        last_col;
    logic [31:0] trem_dec;
    logic [15:0] count_full;
    logic        trunc;
    logic        err_any;

    assign acc_merged = state_i.accumulator
                      | ({56'd0, data_byte_i} << {state_i.byte_index[2:0], 3'b000});
    assign bi_inc     = state_i.byte_index + 4'd1;
    assign col_inc    = state_i.column_index + 16'd1;
    assign last_col   = (col_inc == state_i.columns_total);
    assign trem_dec   = (state_i.text_remaining != 32'd0) ? state_i.text_remaining - 32'd1
                                                          : 32'd0;
    assign count_full = {data_byte_i, state_i.columns_total[7:0]};

    always_comb begin
        prov  = state_i;
        have  = 1'b0;
        err   = 1'b0;
        code  = rrp_pkg::ERR_TRUNCATED;
        kind  = rrp_pkg::KIND_INT;
        value = '0;
        col   = '0;
        case (state_i.phase)
            rrp_pkg::PH_CNT_LO: begin
                prov.columns_total = {8'd0, data_byte_i};
                prov.phase         = rrp_pkg::PH_CNT_HI;
            end
            rrp_pkg::PH_CNT_HI: begin
                prov.columns_total = count_full;
                prov.column_index  = '0;
                if (count_full == 16'd0) begin
                    have       = 1'b1;
                    kind       = rrp_pkg::KIND_EMPTY;
                    prov.phase = rrp_pkg::PH_TRAIL;
                end else begin
                    prov.phase = rrp_pkg::PH_TAG;
                end
            end
            rrp_pkg::PH_TAG: begin
                prov.byte_index  = '0;
                prov.accumulator = '0;
                case (data_byte_i)
                    rrp_pkg::TAG_INT: begin
                        prov.current_type = rrp_pkg::KIND_INT[1:0];
                        prov.phase        = rrp_pkg::PH_FIXED;
                    end
                    rrp_pkg::TAG_FLOAT: begin
                        prov.current_type = rrp_pkg::KIND_FLOAT[1:0];
                        prov.phase        = rrp_pkg::PH_FIXED;
                    end
                    rrp_pkg::TAG_BOOLEAN: begin
                        prov.current_type = rrp_pkg::KIND_BOOL[1:0];
                        prov.phase        = rrp_pkg::PH_BOOL;
                    end
                    rrp_pkg::TAG_TEXT: begin
                        prov.current_type = rrp_pkg::KIND_THDR[1:0];
                        prov.phase        = rrp_pkg::PH_TLEN;
                    end
                    default: begin
                        err  = 1'b1;
                        code = rrp_pkg::ERR_UNKNOWN_TAG;
                        col  = state_i.column_index;
                    end
                endcase
            end
            rrp_pkg::PH_FIXED: begin
                prov.accumulator = acc_merged;
                prov.byte_index  = bi_inc;
                if (bi_inc[3]) begin
                    have              = 1'b1;
                    kind              = {2'b00, state_i.current_type[0]};
                    value             = acc_merged;
                    col               = state_i.column_index;
                    prov.column_index = col_inc;
                    prov.phase        = last_col ? rrp_pkg::PH_TRAIL : rrp_pkg::PH_TAG;
                end
            end
            rrp_pkg::PH_BOOL: begin
                col = state_i.column_index;
                if (data_byte_i > 8'd1) begin
                    err  = 1'b1;
                    code = rrp_pkg::ERR_INVALID_BOOL;
                end else begin
                    have              = 1'b1;
                    kind              = rrp_pkg::KIND_BOOL;
                    value             = {56'd0, data_byte_i};
                    prov.column_index = col_inc;
                    prov.phase        = last_col ? rrp_pkg::PH_TRAIL : rrp_pkg::PH_TAG;
                end
            end
            rrp_pkg::PH_TLEN: begin
                prov.accumulator = acc_merged;
                prov.byte_index  = bi_inc;
                if (bi_inc[3] || bi_inc[2]) begin
                    prov.text_remaining = acc_merged[31:0];
                    have                = 1'b1;
                    kind                = rrp_pkg::KIND_THDR;
                    value               = {32'd0, acc_merged[31:0]};
                    col                 = state_i.column_index;
                    if (acc_merged[31:0] == 32'd0) begin
                        prov.column_index = col_inc;
                        prov.phase = last_col ? rrp_pkg::PH_TRAIL : rrp_pkg::PH_TAG;
                    end else begin
                        prov.phase = rrp_pkg::PH_TEXT;
                    end
                end
            end
            rrp_pkg::PH_TEXT: begin
                have                = 1'b1;
                kind                = rrp_pkg::KIND_TBYTE;
                value               = {56'd0, data_byte_i};
                col                 = state_i.column_index;
                prov.text_remaining = trem_dec;
                if (trem_dec == 32'd0) begin
                    prov.column_index = col_inc;
                    prov.phase        = last_col ? rrp_pkg::PH_TRAIL : rrp_pkg::PH_TAG;
                end
            end
            default: begin
                err  = 1'b1;
                code = rrp_pkg::ERR_TRAILING;
                col  = state_i.column_index;
            end
        endcase
    end

    assign trunc   = !err && end_of_record_i && (prov.phase != rrp_pkg::PH_TRAIL);
    assign err_any = err || trunc;

    always_comb begin
        if (state_i.discarding) begin
            state_next_o = end_of_record_i ? rrp_pkg::PARSE_STATE_RESET : state_i;
        end else if (end_of_record_i) begin
            state_next_o = rrp_pkg::PARSE_STATE_RESET;
        end else begin
            state_next_o            = prov;
            state_next_o.discarding = err_any;
        end
    end

    always_comb begin
        result_o.valid = !state_i.discarding && (err_any || have);
        if (err_any) begin
            result_o.kind       = rrp_pkg::KIND_ERROR;
            result_o.value      = '0;
            result_o.column     = err ? col : prov.column_index;
            result_o.error_code = err ? code : rrp_pkg::ERR_TRUNCATED;
            result_o.last       = 1'b1;
        end else begin
            result_o.kind       = kind;
            result_o.value      = value;
            result_o.column     = col;
            result_o.error_code = rrp_pkg::ERR_TRUNCATED;
            result_o.last       = end_of_record_i;
        end
    end

endmodule

// ===== rtl/row_record_parser_core.sv =====
// ============================================================================
// Row record parser core
// Streaming decoder for serialized table rows, one byte per transaction.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_data_byte, s_end_of_record
//   m_      | out       | m_valid / m_ready  | m_kind, m_value, m_column,
//           |           |                    | m_error_code, m_last
//
// One byte per cycle sustained while results are taken; the step logic sits
// between the input register and the result register that presents a result.
// Reset clears the input and result valid flags and the parser state.
// A stalled result holds the result register; the input register still takes
// one more byte, then s_ready drops until the result is taken.
// ============================================================================
module row_record_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_record,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [2:0]  m_kind,
    output logic [63:0] m_value,
    output logic [15:0] m_column,
    output logic [1:0]  m_error_code,
    output logic        m_last,
    output logic        m_valid,
    input  logic        m_ready
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [7:0]            data_reg;
    logic                  eor_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    rrp_pkg::result_t      result_reg;
    rrp_pkg::parse_state_t state_reg;
    rrp_pkg::parse_state_t state_next;
    rrp_pkg::result_t      step_result;
    logic                  fire;
    logic                  in_take;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign in_take = s_valid && s_ready;

    assign in_valid_next  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = (fire && step_result.valid) ? 1'b1
                          : (m_ready ? 1'b0 : out_valid_reg);

    rrp_step u_step (
        .state_i         (state_reg),
        .data_byte_i     (data_reg),
        .end_of_record_i (eor_reg),
        .state_next_o    (state_next),
        .result_o        (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= rrp_pkg::PARSE_STATE_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            data_reg <= s_data_byte;
            eor_reg  <= s_end_of_record;
        end
        if (fire && step_result.valid) begin
            result_reg <= step_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_kind       = result_reg.kind;
    assign m_value      = result_reg.value;
    assign m_column     = result_reg.column;
    assign m_error_code = result_reg.error_code;
    assign m_last       = result_reg.last;

endmodule
